@@ rtl/lifpair_pkg.sv @@
// Package with types, widths and reset constants of the LIF neuron pair.
package lifpair_pkg;

  // Default synaptic delay in time steps.
  localparam int unsigned DelayTicksDefault = 2;

  // Datapath widths.
  localparam int unsigned ValW    = 16;
  localparam int unsigned RefW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumW    = 19;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned ProdW   = SumW + MulBW;
  localparam int unsigned RndW    = ProdW + 1 - 16;
  localparam int unsigned WideW   = 22;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  // Reset values of the registers and the state.
  localparam logic signed [ValW-1:0] RestReset     = -16'sd16640;
  localparam logic signed [ValW-1:0] ResetPotReset = -16'sd16640;
  localparam logic signed [ValW-1:0] ThreshReset   = -16'sd14080;
  localparam logic signed [ValW-1:0] DriveReset    = 16'sd3072;
  localparam logic [ValW-1:0]        LeakReset     = 16'd3277;
  localparam logic [ValW-1:0]        DecayReset    = 16'd53656;
  localparam logic signed [ValW-1:0] WeightReset   = 16'sd512;
  localparam logic [RefW-1:0]        RefractReset  = 8'd5;
  localparam logic signed [ValW-1:0] PotAReset     = -16'sd16640;
  localparam logic signed [ValW-1:0] PotBReset     = -16'sd20480;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYN_A,
    ST_SYN_B,
    ST_MEM_A,
    ST_MEM_B,
    ST_MEM_END,
    ST_EMIT
  } state_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_REST,
    REG_RESET_POT,
    REG_THRESH,
    REG_DRIVE,
    REG_LEAK,
    REG_DECAY,
    REG_WEIGHT,
    REG_REFRACT
  } cfg_reg_t;

endpackage

@@ rtl/lif_neuron_pair_with_synaptic_delay_top.sv @@
// Two cross-coupled leaky integrate-and-fire neurons sharing one multiplier.
// With advance = 1 an accepted request goes through SYN_A, SYN_B, MEM_A, MEM_B,
// MEM_END and EMIT before the result is registered; with advance = 0 it goes
// straight to EMIT. One request is worked on at a time, and the one shared
// multiplier is used in turn for both decay products and both leak products.
// Synchronous active-high reset restores register defaults and neuron state.
module lif_neuron_pair_with_synaptic_delay_top #(
  parameter int unsigned DELAY_TICKS = lifpair_pkg::DelayTicksDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream; s_tdata: advance[0], zero fill above.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lifpair_pkg::InDataW-1:0]     s_tdata,
  // Output stream; m_tdata: potential_a[15:0], potential_b[31:16],
  // spike_a[32], spike_b[33], zero fill above.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lifpair_pkg::OutDataW-1:0]    m_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [lifpair_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [lifpair_pkg::ValW-1:0]        cfg_data
);

  localparam int unsigned LineW = DELAY_TICKS + 1;
  localparam int unsigned ValW  = lifpair_pkg::ValW;
  localparam int unsigned RefW  = lifpair_pkg::RefW;
  localparam int unsigned SumW  = lifpair_pkg::SumW;
  localparam int unsigned MulBW = lifpair_pkg::MulBW;
  localparam int unsigned ProdW = lifpair_pkg::ProdW;
  localparam int unsigned RndW  = lifpair_pkg::RndW;
  localparam int unsigned WideW = lifpair_pkg::WideW;

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [ValW-1:0] sat16(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(32767);
    lo = -WideW'(32768);
    if (x > hi) begin
      sat16 = 16'sh7FFF;
    end else if (x < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = x[ValW-1:0];
    end
  endfunction

  // Configuration registers.
  logic signed [ValW-1:0] rest_potential;
  logic signed [ValW-1:0] reset_potential;
  logic signed [ValW-1:0] threshold;
  logic signed [ValW-1:0] drive;
  logic [ValW-1:0]        leak_rate;
  logic [ValW-1:0]        syn_decay;
  logic signed [ValW-1:0] syn_weight;
  logic [RefW-1:0]        refractory_ticks;

  // Neuron state.
  logic signed [ValW-1:0] potential [2];
  logic signed [ValW-1:0] current [2];
  logic [RefW-1:0]        ref_count [2];
  logic [LineW-1:0]       delay_line [2];
  logic                   spike [2];

  // Sequencer and datapath registers.
  lifpair_pkg::state_t state;
  lifpair_pkg::state_t state_next;
  logic signed [ProdW-1:0] prod;
  logic                    out_valid;
  logic [lifpair_pkg::OutDataW-1:0] out_data;

  logic                    accept;
  logic                    out_free;
  logic                    load_out;
  logic                    idx;
  logic signed [SumW-1:0]  mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_next;
  logic signed [ProdW:0]   prod_rnd;
  logic signed [RndW-1:0]  rnd;
  logic signed [WideW-1:0] cur_wide;
  logic signed [ValW-1:0]  cur_new;
  logic signed [WideW-1:0] pot_wide;
  logic signed [ValW-1:0]  pot_sat;
  logic                    spk_new;
  logic [RefW-1:0]         ref_new;
  logic signed [ValW-1:0]  pot_new;
  logic                    arrive;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == lifpair_pkg::ST_IDLE);
  assign out_free = !out_valid || m_tready;
  assign load_out = (state == lifpair_pkg::ST_EMIT) && out_free;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rest_potential   <= lifpair_pkg::RestReset;
      reset_potential  <= lifpair_pkg::ResetPotReset;
      threshold        <= lifpair_pkg::ThreshReset;
      drive            <= lifpair_pkg::DriveReset;
      leak_rate        <= lifpair_pkg::LeakReset;
      syn_decay        <= lifpair_pkg::DecayReset;
      syn_weight       <= lifpair_pkg::WeightReset;
      refractory_ticks <= lifpair_pkg::RefractReset;
    end else if (cfg_we) begin
      unique case (lifpair_pkg::cfg_reg_t'(cfg_index))
        lifpair_pkg::REG_REST:      rest_potential   <= cfg_data;
        lifpair_pkg::REG_RESET_POT: reset_potential  <= cfg_data;
        lifpair_pkg::REG_THRESH:    threshold        <= cfg_data;
        lifpair_pkg::REG_DRIVE:     drive            <= cfg_data;
        lifpair_pkg::REG_LEAK:      leak_rate        <= cfg_data;
        lifpair_pkg::REG_DECAY:     syn_decay        <= cfg_data;
        lifpair_pkg::REG_WEIGHT:    syn_weight       <= cfg_data;
        lifpair_pkg::REG_REFRACT:   refractory_ticks <= cfg_data[RefW-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      lifpair_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = s_tdata[0] ? lifpair_pkg::ST_SYN_A : lifpair_pkg::ST_EMIT;
        end
      end
      lifpair_pkg::ST_SYN_A:   state_next = lifpair_pkg::ST_SYN_B;
      lifpair_pkg::ST_SYN_B:   state_next = lifpair_pkg::ST_MEM_A;
      lifpair_pkg::ST_MEM_A:   state_next = lifpair_pkg::ST_MEM_B;
      lifpair_pkg::ST_MEM_B:   state_next = lifpair_pkg::ST_MEM_END;
      lifpair_pkg::ST_MEM_END: state_next = lifpair_pkg::ST_EMIT;
      lifpair_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = lifpair_pkg::ST_IDLE;
        end
      end
      default: state_next = lifpair_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lifpair_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      lifpair_pkg::ST_SYN_A: begin
        mul_a = SumW'(current[0]);
        mul_b = {1'b0, syn_decay};
      end
      lifpair_pkg::ST_SYN_B: begin
        mul_a = SumW'(current[1]);
        mul_b = {1'b0, syn_decay};
      end
      lifpair_pkg::ST_MEM_A: begin
        mul_a = SumW'(rest_potential) - SumW'(potential[0])
              + SumW'(current[0]) + SumW'(drive);
        mul_b = {1'b0, leak_rate};
      end
      lifpair_pkg::ST_MEM_B: begin
        mul_a = SumW'(rest_potential) - SumW'(potential[1])
              + SumW'(current[1]) + SumW'(drive);
        mul_b = {1'b0, leak_rate};
      end
      default: ;
    endcase
  end

  assign prod_next = ProdW'(mul_a * mul_b);

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  // Rounding of the registered product and the per-neuron update.
  // The product of one step is consumed in the step after it, so the
  // neuron index is A in SYN_B and MEM_B, B in MEM_A and MEM_END.
  always_comb begin
    idx      = !((state == lifpair_pkg::ST_SYN_B) || (state == lifpair_pkg::ST_MEM_B));
    prod_rnd = {prod[ProdW-1], prod} + (ProdW+1)'(32768);
    rnd      = prod_rnd[ProdW:16];
    // Spike of the other neuron leaving its delay line.
    arrive   = delay_line[!idx][DELAY_TICKS];
    cur_wide = WideW'(rnd) + (arrive ? WideW'(syn_weight) : WideW'(0));
    cur_new  = sat16(cur_wide);
    pot_wide = WideW'(rnd) + WideW'(potential[idx]);
    pot_sat  = sat16(pot_wide);
    spk_new  = pot_sat > threshold;
    if (spk_new) begin
      ref_new = refractory_ticks;
    end else if (ref_count[idx] != '0) begin
      ref_new = ref_count[idx] - RefW'(1);
    end else begin
      ref_new = '0;
    end
    pot_new = (ref_new != '0) ? reset_potential : pot_sat;
  end

  // Neuron state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      potential[0]  <= lifpair_pkg::PotAReset;
      potential[1]  <= lifpair_pkg::PotBReset;
      current[0]    <= '0;
      current[1]    <= '0;
      ref_count[0]  <= '0;
      ref_count[1]  <= '0;
      delay_line[0] <= '0;
      delay_line[1] <= '0;
      spike[0]      <= 1'b0;
      spike[1]      <= 1'b0;
    end else begin
      if (accept) begin
        spike[0] <= 1'b0;
        spike[1] <= 1'b0;
      end
      if ((state == lifpair_pkg::ST_SYN_B) || (state == lifpair_pkg::ST_MEM_A)) begin
        current[idx] <= cur_new;
      end
      if ((state == lifpair_pkg::ST_MEM_B) || (state == lifpair_pkg::ST_MEM_END)) begin
        potential[idx]  <= pot_new;
        ref_count[idx]  <= ref_new;
        spike[idx]      <= spk_new;
        // Shift the new spike in; the oldest bit drops off the top.
        delay_line[idx] <= LineW'({delay_line[idx], spk_new});
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {6'b0, spike[1], spike[0], potential[1], potential[0]};
    end
  end

endmodule
